[design/mod_prime_power_defines.svh]
// Assertion macros shared by the modular power RTL.
`ifndef MOD_PRIME_POWER_DEFINES_SVH
`define MOD_PRIME_POWER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising edge, ignored while reset is high.
`define MPP_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mod_prime_power: assertion failed");

// Check a property on every rising edge, reset cycles included.
`define MPP_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("mod_prime_power: assertion failed");

`else

`define MPP_ASSERT(name, prop)
`define MPP_ASSERT_ALWAYS(name, prop)

`endif

`endif

[design/mpp_pkg.sv]
// Shared constants and types for the modular power block.
package mpp_pkg;

  // Field widths
  localparam int BASE_W  = 30;
  localparam int EXPO_W  = 32;
  localparam int POWER_W = 30;

  // Default number of exponent bits taking part
  localparam int EXP_BITS_DEF = 32;

  // Modulus and Barrett constants (k = 30, m = floor(2^60 / P))
  localparam logic [29:0] MOD_P     = 30'd1000000007;
  localparam logic [31:0] MOD_P_32  = 32'd1000000007;
  localparam logic [31:0] MOD_P2_32 = 32'd2000000014;
  localparam logic [31:0] MOD_P3_32 = 32'd3000000021;
  localparam logic [30:0] BARRETT_M = 31'd1152921496;

  // Destination of a multiplier result
  typedef enum logic {
    TAG_ACC,
    TAG_SQR
  } mm_tag_t;

  // Control word travelling with an operation through the multiplier
  typedef struct packed {
    logic    valid;
    mm_tag_t tag;
  } mm_ctl_t;

endpackage

[design/mpp_mulmod.sv]
// Pipelined modular multiplier: five stages, Barrett reduction by the prime.
`include "mod_prime_power_defines.svh"

module mpp_mulmod (
  input  logic                        clk,
  input  logic                        rst,
  input  mpp_pkg::mm_ctl_t            op,
  input  logic [29:0]                 x,
  input  logic [29:0]                 y,
  output mpp_pkg::mm_ctl_t            rsp,
  output logic [29:0]                 result,
  output logic                        busy
);

  logic [4:0]          vld;
  mpp_pkg::mm_tag_t    tag [5];

  logic [59:0] prod;
  logic [61:0] est;
  logic [31:0] lo2;
  logic [31:0] qp;
  logic [31:0] lo3;
  logic [31:0] diff;
  logic [29:0] res;

  logic [59:0] prod_next;
  logic [61:0] est_next;
  logic [31:0] qp_next;
  logic [31:0] diff_next;
  logic [31:0] res_wide;

  // Stage arithmetic
  assign prod_next = x * y;
  assign est_next  = prod[59:29] * mpp_pkg::BARRETT_M;
  assign qp_next   = {1'b0, est[61:31]} * {2'b00, mpp_pkg::MOD_P};
  assign diff_next = lo3 - qp;

  // Final correction: estimate is short by at most two multiples
  always_comb begin
    if (diff >= mpp_pkg::MOD_P2_32) begin
      res_wide = diff - mpp_pkg::MOD_P2_32;
    end else if (diff >= mpp_pkg::MOD_P_32) begin
      res_wide = diff - mpp_pkg::MOD_P_32;
    end else begin
      res_wide = diff;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], op.valid};
    end
  end

  // Advance payload and tags
  always_ff @(posedge clk) begin
    tag[0] <= op.tag;
    tag[1] <= tag[0];
    tag[2] <= tag[1];
    tag[3] <= tag[2];
    tag[4] <= tag[3];
    prod   <= prod_next;
    est    <= est_next;
    lo2    <= prod[31:0];
    qp     <= qp_next;
    lo3    <= lo2;
    diff   <= diff_next;
    res    <= res_wide[29:0];
  end

  assign rsp.valid = vld[4];
  assign rsp.tag   = tag[4];
  assign result    = res;
  assign busy      = |vld;

  // Barrett estimate leaves less than three multiples before correction
  `MPP_ASSERT(a_barrett_bound, vld[3] |-> (diff < mpp_pkg::MOD_P3_32))

endmodule

[design/mod_prime_power.sv]
// Top level of the modular power block: base to the exponent modulo 1000000007.
//
// Channels: an argument word (base, exponent) on arg_valid/arg_stall and a result
// word (power) on res_valid/res_stall. A word moves on a rising edge with valid
// high and stall low. The base is reduced modulo the prime on entry.
// Exponent bits are scanned from the low end (right-to-left square-and-multiply);
// each bit sends at most one accumulate multiply and one squaring through the
// shared five-stage modular multiplier and waits for both to drain.
// Each exponent bit up to and including the highest set bit passes through the
// CHECK, SQR and WAIT states before res_valid goes high; a zero exponent gives 1.
// The multiplier pipeline depth sets the per-bit cost: the accumulate multiply
// issues in CHECK, the squaring in SQR, and WAIT drains the five stages.
// One item is worked at a time: arg_stall is high from acceptance until the
// result enters the output register.
// The output register parts the two sides: a finished result waits there while
// res_stall is high, and the next argument word is already taken meanwhile; a
// second result waits inside until the register frees.
// Reset (rst, synchronous) returns the sequencer to idle and drops any result.
`include "mod_prime_power_defines.svh"

module mod_prime_power #(
  parameter int EXP_BITS = mpp_pkg::EXP_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         arg_valid,
  output logic                         arg_stall,
  input  logic [mpp_pkg::BASE_W-1:0]   base,
  input  logic [mpp_pkg::EXPO_W-1:0]   exponent,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [mpp_pkg::POWER_W-1:0]  power
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_SQR   = 4'b0100,
    S_WAIT  = 4'b1000
  } state_t;

  state_t                state;
  state_t                state_next;
  logic [29:0]           acc;
  logic [29:0]           bsq;
  logic [EXP_BITS-1:0]   expo;

  logic                  arg_take;
  logic                  out_free;
  logic                  expo_zero;
  logic [29:0]           base_red;

  mpp_pkg::mm_ctl_t      mm_op;
  mpp_pkg::mm_ctl_t      mm_rsp;
  logic [29:0]           mm_x;
  logic [29:0]           mm_result;
  logic                  mm_busy;

  assign arg_stall = (state != S_IDLE);
  assign arg_take  = arg_valid && !arg_stall;
  assign out_free  = !res_valid || !res_stall;
  assign expo_zero = (expo == '0);

  // Reduce the base once: it is below twice the prime
  assign base_red = (base >= mpp_pkg::MOD_P) ? (base - mpp_pkg::MOD_P) : base;

  // Issue accumulate multiply on a set bit, then square if bits remain
  always_comb begin
    mm_op.valid = ((state == S_CHECK) && !expo_zero && expo[0]) ||
                  ((state == S_SQR) && ((expo >> 1) != '0));
    mm_op.tag   = (state == S_SQR) ? mpp_pkg::TAG_SQR : mpp_pkg::TAG_ACC;
    mm_x        = (state == S_SQR) ? bsq : acc;
  end

  mpp_mulmod u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .op     (mm_op),
    .x      (mm_x),
    .y      (bsq),
    .rsp    (mm_rsp),
    .result (mm_result),
    .busy   (mm_busy)
  );

  // Sequence one exponent bit at a time
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (arg_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!expo_zero) begin
          state_next = S_SQR;
        end else if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_SQR: begin
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (!mm_busy) begin
          state_next = S_CHECK;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CHECK && expo_zero && out_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Load operands, take multiplier results, shift the exponent, post the word
  always_ff @(posedge clk) begin
    if (arg_take) begin
      acc  <= 30'd1;
      bsq  <= base_red;
      expo <= EXP_BITS'(exponent);
    end else begin
      if (mm_rsp.valid) begin
        if (mm_rsp.tag == mpp_pkg::TAG_ACC) begin
          acc <= mm_result;
        end else begin
          bsq <= mm_result;
        end
      end
      if (state == S_WAIT && !mm_busy) begin
        expo <= expo >> 1;
      end
    end
    if (state == S_CHECK && expo_zero && out_free) begin
      power <= acc;
    end
  end

  `MPP_ASSERT(a_power_range, res_valid |-> (power < mpp_pkg::MOD_P))
  `MPP_ASSERT(a_start_clean, arg_take |=> ((state == S_CHECK) && (acc == 30'd1)))
  `MPP_ASSERT(a_rsp_in_wait, mm_rsp.valid |-> (state == S_WAIT))
  `MPP_ASSERT(a_check_drained, (state == S_CHECK) |-> !mm_busy)
  `MPP_ASSERT_ALWAYS(a_reset_idle, rst |=> ((state == S_IDLE) && !res_valid))

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the mod_prime_power modular exponentiation block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int              EXP_BITS     = mpp_pkg::EXP_BITS_DEF;
  localparam int              BASE_W       = mpp_pkg::BASE_W;
  localparam int              EXPO_W       = mpp_pkg::EXPO_W;
  localparam int              POWER_W      = mpp_pkg::POWER_W;
  localparam longint unsigned PRIME        = 64'd1000000007;
  localparam int              RAND_ITEMS   = 850;
  localparam int              DRAIN_CYCLES = 300;
  localparam int              CYCLE_LIMIT  = 3000000;
  localparam int              NUM_ROWS     = 21;

  // Receiver stall behavior, picked anew at random when its run ends
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_t;

  // One directed argument word, with its power where it is obvious
  typedef struct packed {
    logic [BASE_W-1:0]  base;
    logic [EXPO_W-1:0]  exponent;
    bit                 has_power;
    logic [POWER_W-1:0] power;
  } arg_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic arg_valid = 1'b0;
  logic arg_stall;
  logic [BASE_W-1:0] base = '0;
  logic [EXPO_W-1:0] exponent = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic [POWER_W-1:0] power;

  logic [POWER_W-1:0] power_due_q[$];
  logic [POWER_W-1:0] want_power;
  int          err_count   = 0;
  int          cycle_count = 0;
  int          burst_left  = 0;
  int          mode_left   = 0;
  stall_mode_t stall_mode  = STALL_NONE;

  // Extremes, zero and one exponents, bases at or above the prime
  arg_row_t arg_rows [NUM_ROWS] = '{
    '{30'd0,          32'd0,          1'b1, 30'd1},
    '{30'd1000000007, 32'd0,          1'b1, 30'd1},
    '{30'h3FFFFFFF,   32'd0,          1'b1, 30'd1},
    '{30'd5,          32'd1,          1'b1, 30'd5},
    '{30'd1000000007, 32'd1,          1'b1, 30'd0},
    '{30'd1000000012, 32'd1,          1'b1, 30'd5},
    '{30'h3FFFFFFF,   32'd1,          1'b1, 30'd73741816},
    '{30'd0,          32'd5,          1'b1, 30'd0},
    '{30'd0,          32'hFFFFFFFF,   1'b1, 30'd0},
    '{30'd1,          32'hFFFFFFFF,   1'b1, 30'd1},
    '{30'd1000000006, 32'd2,          1'b1, 30'd1},
    '{30'd1000000006, 32'hFFFFFFFF,   1'b1, 30'd1000000006},
    '{30'd2,          32'd10,         1'b1, 30'd1024},
    '{30'd12345,      32'd1000000006, 1'b1, 30'd1},
    '{30'd2,          32'd1000000005, 1'b1, 30'd500000004},
    '{30'd1000000008, 32'hFFFFFFFE,   1'b1, 30'd1},
    '{30'd2,          32'hFFFFFFFF,   1'b0, 30'd0},
    '{30'h3FFFFFFF,   32'hFFFFFFFF,   1'b0, 30'd0},
    '{30'd3,          32'h80000000,   1'b0, 30'd0},
    '{30'd1234567,    32'hAAAAAAAA,   1'b0, 30'd0},
    '{30'h2AAAAAAA,   32'h55555555,   1'b0, 30'd0}
  };

  mod_prime_power #(
    .EXP_BITS(EXP_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .arg_valid(arg_valid),
    .arg_stall(arg_stall),
    .base(base),
    .exponent(exponent),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .power(power)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Square-and-multiply from the top exponent bit, base reduced first
  function automatic logic [POWER_W-1:0] mod_pow(logic [BASE_W-1:0] b,
                                                 logic [EXPO_W-1:0] e);
    longint unsigned acc;
    longint unsigned red;
    acc = 1;
    red = longint'(b) % PRIME;
    for (int i = EXP_BITS - 1; i >= 0; i--) begin
      acc = (acc * acc) % PRIME;
      if (e[i]) begin
        acc = (acc * red) % PRIME;
      end
    end
    return acc[POWER_W-1:0];
  endfunction

  // Offer one argument word, idling between bursts, and log its power once taken
  task automatic send_word(logic [BASE_W-1:0] b, logic [EXPO_W-1:0] e,
                           bit has_power, logic [POWER_W-1:0] pw);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 6);
      if (gap > 0) begin
        arg_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    arg_valid <= 1'b1;
    base      <= b;
    exponent  <= e;
    do @(posedge clk); while (arg_stall);
    power_due_q.push_back(has_power ? pw : mod_pow(b, e));
    burst_left--;
  endtask

  // Drive reset, directed words, then random words, and wait for the drain
  initial begin
    logic [BASE_W-1:0] rb;
    logic [EXPO_W-1:0] re;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < NUM_ROWS; i++) begin
      send_word(arg_rows[i].base, arg_rows[i].exponent, arg_rows[i].has_power,
                arg_rows[i].power);
    end
    for (int i = 0; i < RAND_ITEMS; i++) begin
      case ($urandom_range(0, 9))
        0:       rb = BASE_W'($urandom_range(999999990, 1073741823));
        1:       rb = BASE_W'($urandom_range(0, 15));
        default: rb = BASE_W'($urandom());
      endcase
      case ($urandom_range(0, 9))
        0:       re = $urandom_range(0, 3);
        1:       re = $urandom_range(0, 255);
        2:       re = 32'd1000000005 + $urandom_range(0, 2);
        default: re = $urandom();
      endcase
      send_word(rb, re, 1'b0, '0);
    end
    arg_valid <= 1'b0;
    while (power_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("mod_prime_power verification clean");
    end else begin
      $display("mod_prime_power verification failed");
    end
    $finish;
  end

  // Stall the result side on a pattern of its own
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      mode_left  <= $urandom_range(50, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      STALL_NONE:     res_stall <= 1'b0;
      STALL_COIN:     res_stall <= 1'($urandom_range(0, 1));
      STALL_PERIODIC: res_stall <= (cycle_count[1:0] != 2'b00);
      STALL_HEAVY:    res_stall <= ($urandom_range(0, 15) != 0);
      default:        res_stall <= 1'b0;
    endcase
  end

  // Compare each accepted power word with the oldest one due
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (power_due_q.size() == 0) begin
        $display("%0t: unexpected power word: expected none, actual %0d", $time, power);
        err_count++;
      end else begin
        want_power = power_due_q.pop_front();
        if (power !== want_power) begin
          $display("%0t: power mismatch: expected %0d, actual %0d", $time, want_power, power);
          err_count++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d power words outstanding", $time, power_due_q.size());
      $display("mod_prime_power verification failed");
      $finish;
    end
  end

endmodule
